### rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and codes for the partition range table
// Entry layout, operation and status codes, config register indexes, states.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

	typedef struct packed {
		logic [63:0] start_blk;
		logic [63:0] end_blk;
		logic [63:0] type_lo;
		logic [63:0] type_hi;
		logic [63:0] uniq_lo;
		logic [63:0] uniq_hi;
		logic [63:0] attr;
	} entry_t;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELETE = 2'd1,
		OP_ENUM   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID_DISK = 3'd1,
		ST_BAD_ARG      = 3'd2,
		ST_NO_SPACE     = 3'd3,
		ST_CONFLICT     = 3'd4,
		ST_BAD_HANDLE   = 3'd5,
		ST_NONE         = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_DISK_VALID = 2'd0,
		CFG_FIRST_USE  = 2'd1,
		CFG_LAST_USE   = 2'd2,
		CFG_ENTRY_CNT  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_WRITE,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

### rtl/prt_cell.sv
// ----------------------------------------------------------------------------
// prt_cell: one table entry in the rotating ring
// Holds an entry and takes its neighbor's entry on every shift cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           shift,
	input  wire prt_pkg::entry_t nxt,
	output prt_pkg::entry_t     cur
);

	prt_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= nxt;
		end
	end

	assign cur = ent_q;

endmodule

`default_nettype wire

### rtl/partition_range_table.sv
// ----------------------------------------------------------------------------
// partition_range_table: partition entry table with create/delete/enum/query
// Entries sit in a ring of cells that rotates one lap per scan.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid / in_stall  | kind, handle_present, slot, ranges, ids
//  out     | from block| out_valid / out_stall| status, result_slot, found_*
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Delete, enumerate and query scan the ring once, then pass EVAL and OUT; create
//  checks on one pass, writes on a second (WRITE); items rejected at accept go to OUT.
//  The ring shifts one cell per cycle in SCAN and WRITE; cell 0 is examined by the controller.
//  Reset clears every entry, the config, state and out_valid. One item is in flight
//  at a time; a result waiting on out_stall holds the block before the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module partition_range_table #(
	parameter int TABLE_ENTRIES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic        handle_present,
	input  wire logic [6:0]  slot,
	input  wire logic [63:0] start_block,
	input  wire logic [63:0] end_block,
	input  wire logic [63:0] type_id_low,
	input  wire logic [63:0] type_id_high,
	input  wire logic [63:0] unique_id_low,
	input  wire logic [63:0] unique_id_high,
	input  wire logic [63:0] attribute_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [6:0]       result_slot,
	output logic [63:0]      found_start,
	output logic [63:0]      found_end,
	output logic [63:0]      found_type_low,
	output logic [63:0]      found_type_high,
	output logic [63:0]      found_unique_low,
	output logic [63:0]      found_unique_high
);

	localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CLW = $clog2(TABLE_ENTRIES + 1);
	localparam int LW  = (CLW > 8) ? CLW : 8;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [LW-1:0] N_EXT    = LW'(TABLE_ENTRIES);

	// configuration
	logic        disk_valid_q;
	logic [63:0] first_use_q;
	logic [63:0] last_use_q;
	logic [7:0]  entry_cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_valid_q <= 1'b0;
			first_use_q  <= '0;
			last_use_q   <= '0;
			entry_cnt_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				prt_pkg::CFG_DISK_VALID: disk_valid_q <= cfg_data[0];
				prt_pkg::CFG_FIRST_USE:  first_use_q  <= cfg_data;
				prt_pkg::CFG_LAST_USE:   last_use_q   <= cfg_data;
				prt_pkg::CFG_ENTRY_CNT:  entry_cnt_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ring of cells
	prt_pkg::entry_t cell_out [TABLE_ENTRIES];
	prt_pkg::entry_t feed;
	logic            shift;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		prt_pkg::entry_t nxt_k;
		if (k == TABLE_ENTRIES - 1) begin : g_tail
			assign nxt_k = feed;
		end else begin : g_mid
			assign nxt_k = cell_out[k+1];
		end
		prt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.nxt    (nxt_k),
			.cur    (cell_out[k])
		);
	end

	// controller
	prt_pkg::state_t state_q, state_d;
	logic [IW-1:0]   cnt_q;
	logic            cnt_last;
	prt_pkg::op_t    op_q;
	logic [6:0]      slot_q;
	logic [LW-1:0]   enum_from_q;
	prt_pkg::entry_t req_q;
	prt_pkg::status_t stat_q;
	logic [6:0]      rslot_q;
	logic            conflict_q, free_q, hit_q;
	logic [IW-1:0]   free_idx_q;
	prt_pkg::entry_t found_q;

	prt_pkg::entry_t head;
	logic            head_used, overlap, at_slot, in_enum;
	logic [LW-1:0]   cnt_ext, lim, cnt_bound;
	logic            accept, out_free;
	prt_pkg::status_t acc_stat;

	assign head      = cell_out[0];
	assign head_used = (head.start_blk <= head.end_blk) &&
	                   ((head.type_lo | head.type_hi) != 64'd0);
	assign overlap   = !((req_q.start_blk > head.end_blk) || (req_q.end_blk < head.start_blk));
	assign cnt_ext   = LW'(cnt_q);
	assign cnt_bound = LW'(entry_cnt_q);
	assign lim       = (cnt_bound > N_EXT) ? N_EXT : cnt_bound;
	assign at_slot   = (cnt_ext == LW'(slot_q));
	assign in_enum   = (cnt_ext >= enum_from_q) && (cnt_ext < lim);
	assign cnt_last  = (cnt_q == LAST_IDX);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// status known at accept time
	always_comb begin
		acc_stat = prt_pkg::ST_OK;
		if (!disk_valid_q) begin
			acc_stat = prt_pkg::ST_INVALID_DISK;
		end else begin
			case (prt_pkg::op_t'(kind))
				prt_pkg::OP_CREATE: begin
					if (start_block > end_block) begin
						acc_stat = prt_pkg::ST_BAD_ARG;
					end else if (start_block < first_use_q || end_block > last_use_q) begin
						acc_stat = prt_pkg::ST_NO_SPACE;
					end
				end
				prt_pkg::OP_DELETE: begin
					if (!handle_present || LW'(slot) >= lim) acc_stat = prt_pkg::ST_BAD_HANDLE;
				end
				prt_pkg::OP_ENUM:   acc_stat = prt_pkg::ST_NONE;
				prt_pkg::OP_QUERY: begin
					if (!handle_present || LW'(slot) >= N_EXT) acc_stat = prt_pkg::ST_BAD_HANDLE;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			prt_pkg::S_IDLE: begin
				if (accept) begin
					if (!disk_valid_q) begin
						state_d = prt_pkg::S_OUT;
					end else if (prt_pkg::op_t'(kind) == prt_pkg::OP_CREATE &&
					             (start_block > end_block || start_block < first_use_q ||
					              end_block > last_use_q)) begin
						state_d = prt_pkg::S_OUT;
					end else begin
						state_d = prt_pkg::S_SCAN;
					end
				end
			end
			prt_pkg::S_SCAN:  if (cnt_last) state_d = prt_pkg::S_EVAL;
			prt_pkg::S_EVAL: begin
				if (op_q == prt_pkg::OP_CREATE && !conflict_q && free_q) begin
					state_d = prt_pkg::S_WRITE;
				end else begin
					state_d = prt_pkg::S_OUT;
				end
			end
			prt_pkg::S_WRITE: if (cnt_last) state_d = prt_pkg::S_OUT;
			prt_pkg::S_OUT:   if (out_free) state_d = prt_pkg::S_IDLE;
			default:          state_d = prt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != prt_pkg::S_IDLE);
		shift    = (state_q == prt_pkg::S_SCAN) || (state_q == prt_pkg::S_WRITE);
		feed     = head;
		if (state_q == prt_pkg::S_SCAN && op_q == prt_pkg::OP_DELETE && at_slot &&
		    stat_q == prt_pkg::ST_OK) begin
			feed = '0;
		end else if (state_q == prt_pkg::S_WRITE && cnt_q == free_idx_q) begin
			feed = req_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prt_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (shift) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= prt_pkg::op_t'(kind);
			slot_q      <= slot;
			enum_from_q <= handle_present ? LW'(slot) + 1'b1 : '0;
			req_q       <= '{start_block, end_block, type_id_low, type_id_high,
			                 unique_id_low, unique_id_high, attribute_bits};
			rslot_q     <= '0;
			found_q     <= '0;
			conflict_q  <= 1'b0;
			free_q      <= 1'b0;
			hit_q       <= 1'b0;
			free_idx_q  <= '0;
			stat_q      <= acc_stat;
		end else if (state_q == prt_pkg::S_SCAN) begin
			case (op_q)
				prt_pkg::OP_CREATE: begin
					if (head_used) begin
						if (overlap) conflict_q <= 1'b1;
					end else if (!free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= cnt_q;
					end
				end
				prt_pkg::OP_ENUM: begin
					if (!hit_q && head_used && in_enum) begin
						hit_q   <= 1'b1;
						stat_q  <= prt_pkg::ST_OK;
						rslot_q <= 7'(cnt_q);
					end
				end
				prt_pkg::OP_QUERY: begin
					if (at_slot && stat_q == prt_pkg::ST_OK) found_q <= head;
				end
				default: ;
			endcase
		end else if (state_q == prt_pkg::S_EVAL && op_q == prt_pkg::OP_CREATE) begin
			if (conflict_q) begin
				stat_q <= prt_pkg::ST_CONFLICT;
			end else if (!free_q) begin
				stat_q <= prt_pkg::ST_NO_SPACE;
			end else begin
				rslot_q <= 7'(free_idx_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == prt_pkg::S_OUT && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prt_pkg::S_OUT && out_free) begin
			status            <= stat_q;
			result_slot       <= rslot_q;
			found_start       <= found_q.start_blk;
			found_end         <= found_q.end_blk;
			found_type_low    <= found_q.type_lo;
			found_type_high   <= found_q.type_hi;
			found_unique_low  <= found_q.uniq_lo;
			found_unique_high <= found_q.uniq_hi;
		end
	end

	a_write_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prt_pkg::S_WRITE |-> (free_q && !conflict_q))
		else $error("table write without a free slot");

	a_idle_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == prt_pkg::S_IDLE |-> cnt_q == '0)
		else $error("ring not aligned while idle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("undefined status code");

endmodule

`default_nettype wire

### test/partition_range_table_checker.sv
// ----------------------------------------------------------------------------
// partition_range_table_checker: result predictor and scoreboard
// Tracks register writes and accepted items, keeps a model of the entry table,
// and compares each accepted result against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module partition_range_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  kind,
	input  logic        handle_present,
	input  logic [6:0]  slot,
	input  logic [63:0] start_block,
	input  logic [63:0] end_block,
	input  logic [63:0] type_id_low,
	input  logic [63:0] type_id_high,
	input  logic [63:0] unique_id_low,
	input  logic [63:0] unique_id_high,
	input  logic [63:0] attribute_bits,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [6:0]  result_slot,
	input  logic [63:0] found_start,
	input  logic [63:0] found_end,
	input  logic [63:0] found_type_low,
	input  logic [63:0] found_type_high,
	input  logic [63:0] found_unique_low,
	input  logic [63:0] found_unique_high,
	output int          fail_count,
	output int          pending
);

	localparam int NSLOTS = 128;

	typedef struct packed {
		prt_pkg::status_t st;
		logic [6:0]  rslot;
		logic [63:0] fs, fe, ftl, fth, ful, fuh;
	} answer_t;

	prt_pkg::entry_t table_mdl [NSLOTS];
	logic        disk_ok;
	logic [63:0] first_use, last_use;
	logic [7:0]  ent_cnt;
	answer_t     answers [$];

	assign pending = answers.size();

	function automatic bit in_use(prt_pkg::entry_t e);
		return e.start_blk <= e.end_blk && (e.type_lo != 0 || e.type_hi != 0);
	endfunction

	function automatic int count_bound();
		return (ent_cnt > NSLOTS) ? NSLOTS : int'(ent_cnt);
	endfunction

	task automatic predict_answer();
		answer_t a;
		bit      free_found;
		int      free_idx;
		int      lim;
		a = '0;
		a.st = prt_pkg::ST_OK;
		free_found = 0;
		free_idx = 0;
		if (!disk_ok) begin
			a.st = prt_pkg::ST_INVALID_DISK;
		end else begin
			case (prt_pkg::op_t'(kind))
				prt_pkg::OP_CREATE: begin
					if (start_block > end_block) a.st = prt_pkg::ST_BAD_ARG;
					else if (start_block < first_use || end_block > last_use)
						a.st = prt_pkg::ST_NO_SPACE;
					else begin
						for (int i = 0; i < NSLOTS && a.st == prt_pkg::ST_OK; i++) begin
							if (in_use(table_mdl[i])) begin
								if (!(start_block > table_mdl[i].end_blk ||
										end_block < table_mdl[i].start_blk))
									a.st = prt_pkg::ST_CONFLICT;
							end else if (!free_found) begin
								free_found = 1;
								free_idx = i;
							end
						end
						if (a.st == prt_pkg::ST_OK && !free_found) a.st = prt_pkg::ST_NO_SPACE;
						if (a.st == prt_pkg::ST_OK) begin
							table_mdl[free_idx] = '{start_blk: start_block, end_blk: end_block,
								type_lo: type_id_low, type_hi: type_id_high,
								uniq_lo: unique_id_low, uniq_hi: unique_id_high,
								attr: attribute_bits};
							a.rslot = free_idx[6:0];
						end
					end
				end
				prt_pkg::OP_DELETE: begin
					if (!handle_present || int'(slot) >= count_bound())
						a.st = prt_pkg::ST_BAD_HANDLE;
					else table_mdl[slot] = '0;
				end
				prt_pkg::OP_ENUM: begin
					lim = count_bound();
					a.st = prt_pkg::ST_NONE;
					for (int i = handle_present ? int'(slot) + 1 : 0; i < lim; i++) begin
						if (in_use(table_mdl[i])) begin
							a.st = prt_pkg::ST_OK;
							a.rslot = i[6:0];
							break;
						end
					end
				end
				default: begin
					if (!handle_present) a.st = prt_pkg::ST_BAD_HANDLE;
					else begin
						a.fs  = table_mdl[slot].start_blk;
						a.fe  = table_mdl[slot].end_blk;
						a.ftl = table_mdl[slot].type_lo;
						a.fth = table_mdl[slot].type_hi;
						a.ful = table_mdl[slot].uniq_lo;
						a.fuh = table_mdl[slot].uniq_hi;
					end
				end
			endcase
		end
		answers.push_back(a);
	endtask

	task automatic compare_answer();
		answer_t a;
		answer_t got;
		got = '{st: prt_pkg::status_t'(status), rslot: result_slot, fs: found_start,
			fe: found_end, ftl: found_type_low, fth: found_type_high, ful: found_unique_low,
			fuh: found_unique_high};
		if (answers.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result: status %0d slot %0d", status, result_slot);
		end else begin
			a = answers.pop_front();
			if (a != got) begin
				fail_count++;
				if (fail_count <= 10)
					$display("mismatch: exp st %0d slot %0d %h %h %h %h %h %h, got st %0d slot %0d %h %h %h %h %h %h",
						a.st, a.rslot, a.fs, a.fe, a.ftl, a.fth, a.ful, a.fuh,
						got.st, got.rslot, got.fs, got.fe, got.ftl, got.fth, got.ful, got.fuh);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOTS; i++) table_mdl[i] = '0;
			disk_ok = 0;
			first_use = '0;
			last_use = '0;
			ent_cnt = '0;
			fail_count = 0;
			answers.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (prt_pkg::cfg_idx_t'(cfg_index))
					prt_pkg::CFG_DISK_VALID: disk_ok = cfg_data[0];
					prt_pkg::CFG_FIRST_USE:  first_use = cfg_data;
					prt_pkg::CFG_LAST_USE:   last_use = cfg_data;
					default:                 ent_cnt = cfg_data[7:0];
				endcase
			end
			if (out_valid && !out_stall) compare_answer();
			if (in_valid && !in_stall) predict_answer();
		end
	end

endmodule

### test/partition_range_table_tb.sv
// ----------------------------------------------------------------------------
// partition_range_table_tb: stimulus and verdict for the partition range table
// Directed edge items, then random create/delete/enumerate/query traffic over
// several register settings and idle patterns, including a long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module partition_range_table_tb;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic        handle_present = 0;
	logic [6:0]  slot = '0;
	logic [63:0] start_block = '0, end_block = '0;
	logic [63:0] type_id_low = '0, type_id_high = '0;
	logic [63:0] unique_id_low = '0, unique_id_high = '0;
	logic [63:0] attribute_bits = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [6:0]  result_slot;
	logic [63:0] found_start, found_end, found_type_low, found_type_high;
	logic [63:0] found_unique_low, found_unique_high;
	int          fail_count;
	int          pending;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int cycle_no = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	partition_range_table dut (.*);
	partition_range_table_checker chk (.*);

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stall, or a long hold when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// hold valid after the write; settle drops it
	task automatic write_reg(prt_pkg::cfg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle();
		in_valid <= 0;
		cfg_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic send_item(prt_pkg::op_t k, logic hp, logic [6:0] s, logic [63:0] sb,
			logic [63:0] eb, logic [63:0] tl, logic [63:0] th);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		handle_present <= hp;
		slot <= s;
		start_block <= sb;
		end_block <= eb;
		type_id_low <= tl;
		type_id_high <= th;
		unique_id_low <= rnd64();
		unique_id_high <= rnd64();
		attribute_bits <= rnd64();
		do @(posedge clk); while (in_stall);
	endtask

	// small window keeps overlaps and fill-ups frequent
	task automatic random_item(logic [63:0] lo, logic [63:0] span);
		logic [63:0] sb, eb;
		int r;
		r = $urandom_range(99);
		sb = lo + 64'($urandom_range(32'(span)));
		eb = sb + 64'($urandom_range(3));
		if (r < 5) begin
			sb = rnd64();
			eb = rnd64();
		end
		if (r < 45)
			send_item(prt_pkg::OP_CREATE, 1'($urandom_range(1)), 7'($urandom()), sb, eb,
				($urandom_range(9) == 0) ? 64'd0 : rnd64(),
				($urandom_range(1) == 0) ? 64'd0 : rnd64());
		else
			send_item(prt_pkg::op_t'($urandom_range(3, 1)), $urandom_range(7) != 0,
				($urandom_range(3) == 0) ? 7'($urandom()) : 7'($urandom_range(20)),
				sb, eb, rnd64(), rnd64());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// invalid disk: every kind fails
		for (int k = 0; k < 4; k++)
			send_item(prt_pkg::op_t'(k), 1'b1, 7'd0, 64'd0, 64'd10, 64'd1, 64'd0);
		settle();
		write_reg(prt_pkg::CFG_DISK_VALID, 64'd1);
		write_reg(prt_pkg::CFG_FIRST_USE, 64'd0);
		write_reg(prt_pkg::CFG_LAST_USE, '1);
		write_reg(prt_pkg::CFG_ENTRY_CNT, 64'd255);
		settle();
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd10, 64'd5, 64'd1, 64'd0);   // reversed
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd0, 64'd0, 64'd1, 64'd0);
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, '1, '1, 64'd0, '1);
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd0, 64'd3, 64'd1, 64'd1);    // overlap
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd5, 64'd9, 64'd0, 64'd0);    // zero type
		send_item(prt_pkg::OP_ENUM, 1'b0, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_ENUM, 1'b1, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_ENUM, 1'b1, 7'd127, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_QUERY, 1'b1, 7'd1, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_QUERY, 1'b1, 7'd127, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_QUERY, 1'b0, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_DELETE, 1'b0, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_DELETE, 1'b1, 7'd127, 64'd0, 64'd0, 64'd0, 64'd0);
		send_item(prt_pkg::OP_DELETE, 1'b1, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		settle();
		write_reg(prt_pkg::CFG_FIRST_USE, 64'd100);
		write_reg(prt_pkg::CFG_LAST_USE, 64'd200);
		write_reg(prt_pkg::CFG_ENTRY_CNT, 64'd0);
		settle();
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd99, 64'd150, 64'd1, 64'd0);  // below
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd150, 64'd201, 64'd1, 64'd0); // above
		send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'd100, 64'd200, 64'd1, 64'd0);
		send_item(prt_pkg::OP_ENUM, 1'b0, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);      // count zero
		send_item(prt_pkg::OP_DELETE, 1'b1, 7'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		settle();

		// fill table completely, then create with no space
		write_reg(prt_pkg::CFG_FIRST_USE, 64'd0);
		write_reg(prt_pkg::CFG_LAST_USE, '1);
		write_reg(prt_pkg::CFG_ENTRY_CNT, 64'd128);
		settle();
		for (int i = 0; i < 129; i++)
			send_item(prt_pkg::OP_CREATE, 1'b0, 7'd0, 64'(1000 + i), 64'(1000 + i),
				rnd64() | 64'd1, 64'd0);
		settle();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 77 : 0;
			recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 34 : 0;
			write_reg(prt_pkg::CFG_ENTRY_CNT,
				(ph == 0) ? 64'd20 : (ph == 1) ? 64'd128 : 64'd200);
			write_reg(prt_pkg::CFG_FIRST_USE, (ph == 2) ? 64'd0 : 64'd500);
			write_reg(prt_pkg::CFG_LAST_USE, (ph == 1) ? 64'd560 : '1);
			settle();
			if (ph == 2) hold_cycles = 2000;
			for (int i = 0; i < 480; i++) random_item(64'd490, 64'd80);
			settle();
		end
		write_reg(prt_pkg::CFG_DISK_VALID, 64'd0);
		settle();
		for (int i = 0; i < 20; i++) random_item(64'd0, 64'd10);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/prt_pkg.sv
rtl/prt_cell.sv
rtl/partition_range_table.sv
test/partition_range_table_checker.sv
test/partition_range_table_tb.sv
